@@ hdl/llr_pkg.sv @@
// Shared types and constants for the LL(1) table-driven recognizer.
package llr_pkg;

  localparam logic [2:0] REQ_TBL_WR = 3'd0;
  localparam logic [2:0] REQ_RHS_WR = 3'd1;
  localparam logic [2:0] REQ_BEGIN  = 3'd2;
  localparam logic [2:0] REQ_CHAR   = 3'd3;
  localparam logic [2:0] REQ_END    = 3'd4;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_CONSUMED = 3'd1;
  localparam logic [2:0] ST_SKIPPED  = 3'd2;
  localparam logic [2:0] ST_ACCEPT   = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_NORULE   = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  localparam logic [1:0] SENT_IDLE   = 2'd0;
  localparam logic [1:0] SENT_ACTIVE = 2'd1;
  localparam logic [1:0] SENT_ERROR  = 2'd2;

  localparam logic [7:0] END_MARK = 8'h23;
  localparam logic [7:0] EPSILON  = 8'h24;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam int         NUM_NONTERMINALS = 26;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLEAR, DP_LATCH, DP_TBL_WR, DP_RHS_WR, DP_BEGIN0, DP_BEGIN1,
    DP_STK_RD, DP_TBL_RD, DP_LEN_RD, DP_EXPAND, DP_SYM_RD, DP_PUSH, DP_POP,
    DP_EPS_POP, DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] code;
  } cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic [2:0] req;
    logic [1:0] sent;
    logic [2:0] err;
    logic       is_ws;
    logic       ch_oor;
    logic       count_zero;
    logic       top_nonterm;
    logic       top_eps;
    logic       top_match;
    logic       tbl_valid;
    logic       steps_over;
    logic       ovf;
    logic       len_zero;
    logic       j_last;
    logic       out_hold;
  } stat_t;

endpackage

@@ hdl/llr_datapath.sv @@
// Datapath of the recognizer: memories, stack, counters and output register.
module llr_datapath #(
  parameter int STACK_DEPTH     = 64,
  parameter int NUM_PRODUCTIONS = 64,
  parameter int MAX_RHS         = 8,
  parameter int NUM_TERMINALS   = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  llr_pkg::cmd_t  cmd,
  output llr_pkg::stat_t stat,
  input  logic [2:0]     in_tuser,
  input  logic [39:0]    in_tdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [2:0]     out_tuser,
  output logic [15:0]    out_tdata,
  input  logic           cfg_wr_en,
  input  logic [6:0]     cfg_wr_data
);

  localparam int TBL_DEPTH  = llr_pkg::NUM_NONTERMINALS * NUM_TERMINALS;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);
  localparam int SYM_DEPTH  = NUM_PRODUCTIONS * MAX_RHS;
  localparam int SYM_AW     = $clog2(SYM_DEPTH);
  localparam int PROD_AW    = $clog2(NUM_PRODUCTIONS);
  localparam int SAW        = $clog2(STACK_DEPTH);
  localparam int CW         = $clog2(STACK_DEPTH + 1);
  localparam int LEN_W      = $clog2(MAX_RHS + 1);
  localparam int STEP_LIMIT = 16 * STACK_DEPTH;
  localparam int STW        = $clog2(STEP_LIMIT + 1);
  localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TBL_DEPTH - 1);
  localparam logic [TBL_AW-1:0] TBL_COLS = TBL_AW'(NUM_TERMINALS);
  localparam logic [SYM_AW-1:0] SYM_ROW  = SYM_AW'(MAX_RHS);
  localparam logic [CW:0]       OVF_LIM  = (CW + 1)'(STACK_DEPTH + 1);

  logic [6:0]  tbl_mem [TBL_DEPTH];
  logic [7:0]  sym_mem [SYM_DEPTH];
  logic [LEN_W-1:0] len_mem [NUM_PRODUCTIONS];
  logic [7:0]  stk_mem [STACK_DEPTH];

  logic [6:0]        tbl_q_r;
  logic [7:0]        sym_q_r;
  logic [LEN_W-1:0]  len_q_r;
  logic [7:0]        stk_q_r;

  logic [2:0] req_r;
  logic [4:0] nt_r;
  logic [6:0] term_r;
  logic       ev_r;
  logic [5:0] prod_r;
  logic [2:0] slot_r;
  logic [3:0] rlen_r;
  logic [7:0] sym_r;
  logic [5:0] xprod_r;
  logic [LEN_W-1:0] j_r;
  logic [STW-1:0]   steps_r;
  logic [CW-1:0]    count_r;
  logic [TBL_AW-1:0] clr_r;
  logic [1:0]  sent_r;
  logic [2:0]  err_r;
  logic [15:0] chars_r;
  logic [6:0]  start_r;
  logic        oval_r;
  logic [2:0]  ostat_r;
  logic [15:0] opos_r;

  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_wa;
  logic [6:0]        tbl_wd;
  logic [TBL_AW-1:0] tbl_ra;
  logic [7:0]        row;
  logic              wr_ok_tbl;
  logic              wr_ok_rhs;
  logic [LEN_W-1:0]  len_sat;
  logic [SYM_AW-1:0] sym_wa;
  logic [SYM_AW-1:0] sym_ra;
  logic [LEN_W-1:0]  j_m1;

  assign row       = stk_q_r - llr_pkg::CH_A;
  assign tbl_ra    = TBL_AW'(row[4:0]) * TBL_COLS + TBL_AW'(sym_r);
  assign wr_ok_tbl = (32'(nt_r) < llr_pkg::NUM_NONTERMINALS) &&
                     (32'(term_r) < NUM_TERMINALS) && (32'(prod_r) < NUM_PRODUCTIONS);
  assign wr_ok_rhs = (32'(prod_r) < NUM_PRODUCTIONS) && (32'(slot_r) < MAX_RHS);
  assign len_sat   = (32'(rlen_r) > MAX_RHS) ? LEN_W'(MAX_RHS) : LEN_W'(rlen_r);
  assign sym_wa    = SYM_AW'(prod_r) * SYM_ROW + SYM_AW'(slot_r);
  assign j_m1      = j_r - LEN_W'(1);
  assign sym_ra    = SYM_AW'(xprod_r) * SYM_ROW + SYM_AW'(j_m1);

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = clr_r;
    tbl_wd = 7'd0;
    if (cmd.op == llr_pkg::DP_CLEAR) begin
      tbl_we = 1'b1;
    end else if (cmd.op == llr_pkg::DP_TBL_WR && wr_ok_tbl) begin
      tbl_we = 1'b1;
      tbl_wa = TBL_AW'(nt_r) * TBL_COLS + TBL_AW'(term_r);
      tbl_wd = {ev_r, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (cmd.op == llr_pkg::DP_TBL_RD) begin
      tbl_q_r <= tbl_mem[tbl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == llr_pkg::DP_RHS_WR && wr_ok_rhs) begin
      sym_mem[sym_wa] <= sym_r;
      len_mem[PROD_AW'(prod_r)] <= len_sat;
    end
    if (cmd.op == llr_pkg::DP_SYM_RD) begin
      sym_q_r <= sym_mem[sym_ra];
    end
    if (cmd.op == llr_pkg::DP_LEN_RD) begin
      len_q_r <= len_mem[PROD_AW'(tbl_q_r[5:0])];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      llr_pkg::DP_BEGIN0: stk_mem[SAW'(0)] <= llr_pkg::END_MARK;
      llr_pkg::DP_BEGIN1: stk_mem[SAW'(1)] <= {1'b0, start_r};
      llr_pkg::DP_PUSH:   stk_mem[count_r[SAW-1:0]] <= sym_q_r;
      default: ;
    endcase
    if (cmd.op == llr_pkg::DP_STK_RD) begin
      stk_q_r <= stk_mem[SAW'(count_r - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == llr_pkg::DP_LATCH) begin
      req_r  <= in_tuser;
      nt_r   <= in_tdata[4:0];
      term_r <= in_tdata[11:5];
      ev_r   <= in_tdata[12];
      prod_r <= in_tdata[18:13];
      slot_r <= in_tdata[21:19];
      rlen_r <= in_tdata[25:22];
      sym_r  <= in_tdata[33:26];
    end
    if (cmd.op == llr_pkg::DP_LEN_RD) begin
      xprod_r <= tbl_q_r[5:0];
    end
    if (cmd.op == llr_pkg::DP_EXPAND) begin
      j_r <= len_q_r;
    end else if (cmd.op == llr_pkg::DP_PUSH) begin
      j_r <= j_m1;
    end
    if (cmd.op == llr_pkg::DP_LATCH) begin
      steps_r <= '0;
    end else if (cmd.op == llr_pkg::DP_LEN_RD || cmd.op == llr_pkg::DP_EPS_POP) begin
      steps_r <= steps_r + STW'(1);
    end
    if (cmd.op == llr_pkg::DP_FINISH) begin
      ostat_r <= cmd.code;
      opos_r  <= chars_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      clr_r   <= '0;
      sent_r  <= llr_pkg::SENT_IDLE;
      err_r   <= llr_pkg::ST_LOADED;
      chars_r <= '0;
      start_r <= 7'h41;
      oval_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
      if (cmd.op == llr_pkg::DP_CLEAR) begin
        clr_r <= clr_r + TBL_AW'(1);
      end
      case (cmd.op)
        llr_pkg::DP_BEGIN1: begin
          count_r <= CW'(2);
          sent_r  <= llr_pkg::SENT_ACTIVE;
          err_r   <= llr_pkg::ST_LOADED;
          chars_r <= '0;
        end
        llr_pkg::DP_EXPAND: count_r <= count_r - CW'(1);
        llr_pkg::DP_PUSH:   count_r <= count_r + CW'(1);
        llr_pkg::DP_POP, llr_pkg::DP_EPS_POP: count_r <= count_r - CW'(1);
        llr_pkg::DP_FINISH: begin
          if (req_r == llr_pkg::REQ_CHAR && sent_r != llr_pkg::SENT_IDLE) begin
            if (chars_r != 16'hFFFF) begin
              chars_r <= chars_r + 16'd1;
            end
            if (sent_r == llr_pkg::SENT_ACTIVE && cmd.code != llr_pkg::ST_CONSUMED &&
                cmd.code != llr_pkg::ST_SKIPPED) begin
              sent_r <= llr_pkg::SENT_ERROR;
              err_r  <= cmd.code;
            end
          end else if (req_r == llr_pkg::REQ_END) begin
            sent_r <= llr_pkg::SENT_IDLE;
          end
        end
        default: ;
      endcase
      if (cmd.op == llr_pkg::DP_FINISH) begin
        oval_r <= 1'b1;
      end else if (out_tready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.clear_last  = (clr_r == TBL_LAST);
    stat.req         = req_r;
    stat.sent        = sent_r;
    stat.err         = err_r;
    stat.is_ws       = (sym_r == llr_pkg::CH_SPACE) || (sym_r == llr_pkg::CH_LF) ||
                       (sym_r == llr_pkg::CH_TAB);
    stat.ch_oor      = (32'(sym_r) >= NUM_TERMINALS);
    stat.count_zero  = (count_r == '0);
    stat.top_nonterm = (stk_q_r >= llr_pkg::CH_A) && (stk_q_r <= llr_pkg::CH_Z);
    stat.top_eps     = (stk_q_r == llr_pkg::EPSILON);
    stat.top_match   = (stk_q_r == sym_r);
    stat.tbl_valid   = tbl_q_r[6];
    stat.steps_over  = (32'(steps_r) >= STEP_LIMIT);
    stat.ovf         = ((CW + 1)'(count_r) + (CW + 1)'(len_q_r)) > OVF_LIM;
    stat.len_zero    = (len_q_r == '0);
    stat.j_last      = (j_r == LEN_W'(1));
    stat.out_hold    = oval_r && !out_tready;
  end

  assign out_tvalid = oval_r;
  assign out_tuser  = ostat_r;
  assign out_tdata  = opos_r;

endmodule

@@ hdl/llr_ctrl.sv @@
// Controller state machine that sequences requests and parse steps.
module llr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  llr_pkg::stat_t stat,
  output llr_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_BEGIN1, S_STK_RD, S_EVAL, S_TBL, S_LEN,
    S_SYM_RD, S_PUSH, S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] code_r, code_nxt;

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd.op    = llr_pkg::DP_NOP;
    cmd.code  = code_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = llr_pkg::DP_CLEAR;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = llr_pkg::DP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        code_nxt  = llr_pkg::ST_LOADED;
        state_nxt = S_FINISH;
        case (stat.req)
          llr_pkg::REQ_TBL_WR: cmd.op = llr_pkg::DP_TBL_WR;
          llr_pkg::REQ_RHS_WR: cmd.op = llr_pkg::DP_RHS_WR;
          llr_pkg::REQ_BEGIN: begin
            cmd.op    = llr_pkg::DP_BEGIN0;
            state_nxt = S_BEGIN1;
          end
          llr_pkg::REQ_CHAR: begin
            if (stat.sent == llr_pkg::SENT_IDLE) begin
              code_nxt = llr_pkg::ST_MISMATCH;
            end else if (stat.sent == llr_pkg::SENT_ERROR) begin
              code_nxt = stat.err;
            end else if (stat.is_ws) begin
              code_nxt = llr_pkg::ST_SKIPPED;
            end else begin
              state_nxt = S_STK_RD;
            end
          end
          llr_pkg::REQ_END: begin
            if (stat.sent == llr_pkg::SENT_ACTIVE) begin
              code_nxt = llr_pkg::ST_ACCEPT;
            end else if (stat.sent == llr_pkg::SENT_ERROR) begin
              code_nxt = stat.err;
            end else begin
              code_nxt = llr_pkg::ST_MISMATCH;
            end
          end
          default: ;
        endcase
      end
      S_BEGIN1: begin
        cmd.op    = llr_pkg::DP_BEGIN1;
        state_nxt = S_FINISH;
      end
      S_STK_RD: begin
        if (stat.count_zero) begin
          code_nxt  = llr_pkg::ST_CONSUMED;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = llr_pkg::DP_STK_RD;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_FINISH;
        if (stat.top_nonterm) begin
          if (stat.ch_oor) begin
            code_nxt = llr_pkg::ST_NORULE;
          end else begin
            cmd.op    = llr_pkg::DP_TBL_RD;
            state_nxt = S_TBL;
          end
        end else if (stat.top_eps) begin
          if (stat.steps_over) begin
            code_nxt = llr_pkg::ST_NORULE;
          end else begin
            cmd.op    = llr_pkg::DP_EPS_POP;
            state_nxt = S_STK_RD;
          end
        end else if (stat.top_match) begin
          cmd.op   = llr_pkg::DP_POP;
          code_nxt = llr_pkg::ST_CONSUMED;
        end else begin
          code_nxt = llr_pkg::ST_MISMATCH;
        end
      end
      S_TBL: begin
        if (!stat.tbl_valid || stat.steps_over) begin
          code_nxt  = llr_pkg::ST_NORULE;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = llr_pkg::DP_LEN_RD;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (stat.ovf) begin
          code_nxt  = llr_pkg::ST_OVERFLOW;
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = llr_pkg::DP_EXPAND;
          state_nxt = stat.len_zero ? S_STK_RD : S_SYM_RD;
        end
      end
      S_SYM_RD: begin
        cmd.op    = llr_pkg::DP_SYM_RD;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.op    = llr_pkg::DP_PUSH;
        state_nxt = stat.j_last ? S_STK_RD : S_SYM_RD;
      end
      S_FINISH: begin
        if (!stat.out_hold) begin
          cmd.op    = llr_pkg::DP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      code_r  <= llr_pkg::ST_LOADED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

@@ hdl/ll1_table_driven_recognizer.sv @@
// Top level of the LL(1) table-driven recognizer.
// Requests enter on the in_ channel: in_tuser carries the request type and
// in_tdata the table, production and character fields. Every request gives
// exactly one response on the out_ channel, with the status code in out_tuser
// and the character position in out_tdata. The start symbol is written
// through cfg_wr_en and cfg_wr_data; the user must do so only while no
// request is in flight, as the block does not enforce it. Table and
// production writes, end, whitespace and unknown request types go from
// dispatch to finish; begin first writes the stack bottom and start symbol.
// A parse character reads the stack top anew after each epsilon pop and
// expansion; each of its table, length and symbol reads is registered.
// One request is processed at a time; the next one can be accepted in the
// same cycle that the response appears. A finished response waits in the output
// register, so the next request is accepted while the receiver stalls; a
// further response is held until the register is taken.
// After reset the prediction table is cleared one entry per cycle, all 26 times
// the number of terminals entries (3328 by default), and in_tready stays low.
module ll1_table_driven_recognizer #(
  parameter int STACK_DEPTH     = 64,
  parameter int NUM_PRODUCTIONS = 64,
  parameter int MAX_RHS         = 8,
  parameter int NUM_TERMINALS   = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,    // req_type
  input  logic [39:0] in_tdata,    // nonterminal, terminal, entry_valid, production,
                                   // slot, rhs_length, symbol, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,   // status
  output logic [15:0] out_tdata,   // position
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  llr_pkg::cmd_t  cmd;
  llr_pkg::stat_t stat;

  llr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  llr_datapath #(
    .STACK_DEPTH     (STACK_DEPTH),
    .NUM_PRODUCTIONS (NUM_PRODUCTIONS),
    .MAX_RHS         (MAX_RHS),
    .NUM_TERMINALS   (NUM_TERMINALS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

@@ tb/sv/ll1_table_driven_recognizer_checker.sv @@
// Checker that predicts and compares every response of the LL(1) recognizer.
module ll1_table_driven_recognizer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [2:0]  in_tuser,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [2:0]  out_tuser,
  input  logic [15:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending,
  output int          accept_count
);

  localparam int DEPTH = 64;
  localparam int NPROD = 64;
  localparam int NRHS  = 8;
  localparam int NTERM = 128;
  localparam int STEP_MAX = 16 * DEPTH;
  localparam int NROWS = llr_pkg::NUM_NONTERMINALS;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] position;
  } resp_t;

  resp_t       resp_q[$];
  logic [7:0]  stk[DEPTH];
  int          stk_cnt;
  logic        row_ok[NROWS * NTERM];
  logic [5:0]  row_prod[NROWS * NTERM];
  logic [7:0]  rhs_sym[NPROD * NRHS];
  logic [3:0]  rhs_len[NPROD];
  logic [1:0]  sent;
  logic [15:0] chars;
  logic [2:0]  latched;
  logic [6:0]  start_sym;

  function automatic logic [2:0] parse_one(input logic [7:0] ch);
    int steps;
    int idx;
    int len;
    logic [7:0] top;
    logic [5:0] p;
    steps = 0;
    while (stk_cnt > 0) begin
      top = stk[stk_cnt - 1];
      if (top >= llr_pkg::CH_A && top <= llr_pkg::CH_Z) begin
        if (ch >= NTERM) return llr_pkg::ST_NORULE;
        idx = (top - llr_pkg::CH_A) * NTERM + ch;
        if (!row_ok[idx]) return llr_pkg::ST_NORULE;
        p = row_prod[idx];
        steps++;
        if (steps > STEP_MAX) return llr_pkg::ST_NORULE;
        len = rhs_len[p];
        if (stk_cnt - 1 + len > DEPTH) return llr_pkg::ST_OVERFLOW;
        stk_cnt--;
        for (int j = len; j > 0; j--) begin
          stk[stk_cnt] = rhs_sym[p * NRHS + j - 1];
          stk_cnt++;
        end
      end else if (top == llr_pkg::EPSILON) begin
        steps++;
        if (steps > STEP_MAX) return llr_pkg::ST_NORULE;
        stk_cnt--;
      end else begin
        if (top != ch) return llr_pkg::ST_MISMATCH;
        stk_cnt--;
        return llr_pkg::ST_CONSUMED;
      end
    end
    return llr_pkg::ST_CONSUMED;
  endfunction

  function automatic resp_t predict_response(input logic [2:0] req, input logic [39:0] d);
    logic [4:0] nt;
    logic [6:0] term;
    logic [5:0] prod;
    logic [2:0] slot;
    logic [3:0] len;
    logic [7:0] sym;
    resp_t r;
    nt = d[4:0];
    term = d[11:5];
    prod = d[18:13];
    slot = d[21:19];
    len = d[25:22];
    sym = d[33:26];
    r.status = llr_pkg::ST_LOADED;
    r.position = chars;
    case (req)
      llr_pkg::REQ_TBL_WR: begin
        if (nt < NROWS) begin
          row_ok[nt * NTERM + term] = d[12];
          row_prod[nt * NTERM + term] = prod;
        end
      end
      llr_pkg::REQ_RHS_WR: begin
        rhs_sym[prod * NRHS + slot] = sym;
        rhs_len[prod] = (len > NRHS) ? 4'(NRHS) : len;
      end
      llr_pkg::REQ_BEGIN: begin
        stk[0] = llr_pkg::END_MARK;
        stk[1] = {1'b0, start_sym};
        stk_cnt = 2;
        sent = llr_pkg::SENT_ACTIVE;
        chars = '0;
        latched = '0;
        r.position = '0;
      end
      llr_pkg::REQ_CHAR: begin
        if (sent == llr_pkg::SENT_IDLE) begin
          r.status = llr_pkg::ST_MISMATCH;
        end else begin
          if (sent == llr_pkg::SENT_ERROR) begin
            r.status = latched;
          end else if (sym == llr_pkg::CH_SPACE || sym == llr_pkg::CH_LF ||
                       sym == llr_pkg::CH_TAB) begin
            r.status = llr_pkg::ST_SKIPPED;
          end else begin
            r.status = parse_one(sym);
            if (r.status != llr_pkg::ST_CONSUMED) begin
              latched = r.status;
              sent = llr_pkg::SENT_ERROR;
            end
          end
          if (chars != 16'hFFFF) chars++;
        end
      end
      llr_pkg::REQ_END: begin
        if (sent == llr_pkg::SENT_ACTIVE) r.status = llr_pkg::ST_ACCEPT;
        else if (sent == llr_pkg::SENT_ERROR) r.status = latched;
        else r.status = llr_pkg::ST_MISMATCH;
        sent = llr_pkg::SENT_IDLE;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    resp_t want;
    if (!rst_n) begin
      resp_q.delete();
      for (int i = 0; i < NROWS * NTERM; i++) row_ok[i] = 1'b0;
      stk_cnt = 0;
      sent = llr_pkg::SENT_IDLE;
      chars = '0;
      latched = '0;
      start_sym = 7'h41;
      fail_count = 0;
      accept_count = 0;
    end else begin
      if (cfg_wr_en) start_sym = cfg_wr_data;
      if (in_tvalid && in_tready) resp_q = {resp_q, predict_response(in_tuser, in_tdata)};
      if (out_tvalid && out_tready) begin
        if (resp_q.size() == 0) begin
          $error("response with no request waiting: status %0d position %0d",
                 out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = resp_q.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_tdata);
            fail_count++;
          end
          if (want.status == llr_pkg::ST_ACCEPT) accept_count++;
        end
      end
    end
    pending = resp_q.size();
  end

endmodule

@@ tb/sv/ll1_table_driven_recognizer_tb.sv @@
// Testbench top: drives requests and configuration and reports the verdict.
module ll1_table_driven_recognizer_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser = '0;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;
  logic [15:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = 7'h41;
  int          fail_count;
  int          pending;
  int          accept_count;
  int          sent_count = 0;
  int          sentences = 0;
  logic        calm = 1'b1;

  always #10 clk = ~clk;

  ll1_table_driven_recognizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  ll1_table_driven_recognizer_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .accept_count(accept_count)
  );

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 10);
  end

  initial begin
    #80_000_000;
    $display("ll1_table_driven_recognizer_tb NOT OK");
    $finish;
  end

  task automatic send(input logic [2:0] req, input logic [4:0] nt, input logic [6:0] term,
                      input logic ev, input logic [5:0] prod, input logic [2:0] slot,
                      input logic [3:0] len, input logic [7:0] sym);
    while (!calm && $urandom_range(99) < 10) begin
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {6'b0, sym, len, slot, prod, ev, term, nt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic put_entry(input logic [7:0] row, input logic [7:0] col,
                           input logic [5:0] prod);
    send(llr_pkg::REQ_TBL_WR, 5'(row - llr_pkg::CH_A), col[6:0], 1'b1, prod, 3'd0, 4'd0,
         8'd0);
  endtask

  task automatic put_rhs(input logic [5:0] prod, input string rhs);
    for (int i = 0; i < rhs.len(); i++)
      send(llr_pkg::REQ_RHS_WR, 5'd0, 7'd0, 1'b0, prod, 3'(i), 4'(rhs.len()), rhs[i]);
  endtask

  task automatic feed(input logic [7:0] ch);
    send(llr_pkg::REQ_CHAR, 5'($urandom), 7'($urandom), 1'($urandom), 6'($urandom),
         3'($urandom), 4'($urandom), ch);
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) feed(s[i]);
  endtask

  task automatic open_sentence();
    send(llr_pkg::REQ_BEGIN, 5'($urandom), 7'($urandom), 1'($urandom), 6'($urandom),
         3'($urandom), 4'($urandom), 8'($urandom));
    sentences++;
  endtask

  task automatic close_sentence();
    send(llr_pkg::REQ_END, 5'($urandom), 7'($urandom), 1'($urandom), 6'($urandom),
         3'($urandom), 4'($urandom), 8'($urandom));
  endtask

  task automatic set_start(input logic [6:0] s);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= s;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic noise();
    logic [2:0] req;
    logic [5:0] prod;
    req = 3'($urandom_range(7));
    case (req)
      llr_pkg::REQ_TBL_WR: begin
        prod = ($urandom_range(3) == 0) ? 6'd63 : 6'($urandom_range(7));
        send(req, 5'($urandom_range(2) == 0 ? $urandom_range(26, 31) : $urandom_range(25)),
             7'($urandom), 1'($urandom), prod, 3'($urandom), 4'($urandom), 8'($urandom));
      end
      llr_pkg::REQ_RHS_WR:
        send(req, 5'($urandom), 7'($urandom), 1'($urandom), 6'($urandom_range(8, 62)),
             3'($urandom), 4'($urandom), 8'($urandom));
      llr_pkg::REQ_BEGIN: open_sentence();
      llr_pkg::REQ_CHAR:  feed(8'($urandom));
      llr_pkg::REQ_END:   close_sentence();
      default:
        send(req, 5'($urandom), 7'($urandom), 1'($urandom), 6'($urandom), 3'($urandom),
             4'($urandom), 8'($urandom));
    endcase
  endtask

  function automatic string blank_char();
    case ($urandom_range(2))
      0: return " ";
      1: return "\n";
      default: return "\t";
    endcase
  endfunction

  task automatic random_sentence();
    string s;
    int n;
    int k;
    int cut;
    n = ($urandom_range(19) == 0) ? $urandom_range(55, 66) : $urandom_range(8);
    k = $urandom_range(5);
    s = "";
    for (int i = 0; i < n; i++) s = {s, "a"};
    if ($urandom_range(1)) begin
      s = {s, "x"};
      for (int i = 0; i < k; i++) s = {s, "y"};
      s = {s, $urandom_range(1) ? "z" : "w"};
    end
    for (int i = 0; i < n; i++) s = {s, "b"};
    if ($urandom_range(4) == 0 && s.len() > 0) begin
      cut = $urandom_range(s.len() - 1);
      s[cut] = 8'($urandom);
    end
    open_sentence();
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(9) == 0) feed_text(blank_char());
      feed(s[i]);
    end
    if ($urandom_range(9) == 0) feed_text("#q");
    if ($urandom_range(9) != 0) close_sentence();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Empty table: a char in an idle recognizer, then a start with no rule.
    feed("a");
    close_sentence();
    open_sentence();
    feed("a");
    feed("b");
    close_sentence();

    put_rhs(6'd0, "aSb");
    put_rhs(6'd1, "$");
    put_rhs(6'd2, "xX");
    put_rhs(6'd3, "yX");
    put_rhs(6'd4, "z");
    put_rhs(6'd5, "qqqqqqqq");
    put_rhs(6'd6, "L");
    send(llr_pkg::REQ_RHS_WR, 5'd0, 7'd0, 1'b0, 6'd7, 3'd0, 4'd0, 8'd0);
    for (int i = 0; i < 8; i++)
      send(llr_pkg::REQ_RHS_WR, 5'd31, 7'h7F, 1'b1, 6'd63, 3'(i), 4'd15, 8'hFF - 8'(i));
    put_entry("S", "a", 6'd0);
    put_entry("S", "b", 6'd1);
    put_entry("S", "x", 6'd2);
    put_entry("X", "y", 6'd3);
    put_entry("X", "z", 6'd4);
    put_entry("X", "w", 6'd7);
    put_entry("X", 8'h7F, 6'd63);
    put_entry("Z", "q", 6'd5);
    put_entry("L", "l", 6'd6);
    send(llr_pkg::REQ_TBL_WR, 5'd31, 7'h7F, 1'b1, 6'd63, 3'd7, 4'd15, 8'hFF);
    send(llr_pkg::REQ_TBL_WR, 5'd25, 7'h7E, 1'b0, 6'd63, 3'd7, 4'd15, 8'hFF);

    set_start("S");
    open_sentence();
    feed_text("aa \n\txyywbb#qr");
    close_sentence();
    open_sentence();
    feed_text("axy");
    feed(8'h7F);
    close_sentence();
    open_sentence();
    feed(8'hFF);
    feed("a");
    close_sentence();
    open_sentence();
    feed_text("b");
    close_sentence();
    send(3'd7, 5'd0, 7'd0, 1'b0, 6'd0, 3'd0, 4'd0, 8'd0);

    set_start("Z");
    open_sentence();
    feed_text("qqqqqqqq");
    close_sentence();
    set_start("L");
    open_sentence();
    feed("l");
    feed("l");
    close_sentence();
    set_start("A");
    open_sentence();
    for (int i = 0; i < 40; i++) feed(" ");
    close_sentence();

    set_start("S");
    while (sent_count < 900) begin
      if (sent_count > 500) calm = 1'b0;
      if ($urandom_range(9) < 7) random_sentence();
      else noise();
    end
    set_start(7'h5A);
    open_sentence();
    feed_text("qqqqqqqqq");
    close_sentence();

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Sent %0d requests over %0d sentences, %0d of them accepted.",
             sent_count, sentences, accept_count);
    $display("Start symbol took four settings, including both ends of its range.");
    if (fail_count == 0) begin
      $display("ll1_table_driven_recognizer_tb OK");
    end else begin
      $display("ll1_table_driven_recognizer_tb NOT OK");
    end
    $finish;
  end

endmodule
